@@ design/bfm_pkg.sv @@
// shared types, codes and symbol decoder for the brainfuck machine
package bfm_pkg;

  localparam int PROG_DEPTH_DEF = 1024;
  localparam int TAPE_CELLS_DEF = 1024;
  localparam int NEST_DEPTH_DEF = 64;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_INC   = 3'd0,
    OP_DEC   = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_OPEN  = 3'd4,
    OP_CLOSE = 3'd5,
    OP_OUT   = 3'd6,
    OP_IN    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_HALT  = 3'd1,
    ST_WAIT  = 3'd2,
    ST_CLOSE = 3'd3,
    ST_OPEN  = 3'd4,
    ST_OVER  = 3'd5
  } status_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } dec_t;

  typedef struct packed {
    logic prog_we;
    logic push;
    logic tab_we;
  } prog_ctl_t;

  function automatic dec_t decode_symbol(input logic [7:0] c);
    dec_t d;
    d.vld = 1'b1;
    d.op  = OP_INC;
    unique case (c)
      CH_PLUS:  d.op = OP_INC;
      CH_MINUS: d.op = OP_DEC;
      CH_LT:    d.op = OP_LEFT;
      CH_GT:    d.op = OP_RIGHT;
      CH_LBRK:  d.op = OP_OPEN;
      CH_RBRK:  d.op = OP_CLOSE;
      CH_DOT:   d.op = OP_OUT;
      CH_COMMA: d.op = OP_IN;
      default:  d.vld = 1'b0;
    endcase
    return d;
  endfunction

endpackage

@@ design/bfm_prog.sv @@
// program store, bracket match tables and bracket stack with prefetched reads
module bfm_prog #(
  parameter int PROG_DEPTH = bfm_pkg::PROG_DEPTH_DEF,
  parameter int NEST_DEPTH = bfm_pkg::NEST_DEPTH_DEF,
  parameter int PW = $clog2(PROG_DEPTH),
  parameter int SW = $clog2(NEST_DEPTH)
) (
  input  logic                clk,
  input  bfm_pkg::prog_ctl_t  ctl,
  input  logic [PW-1:0]       wr_pos,
  input  bfm_pkg::op_t        wr_op,
  input  logic [PW-1:0]       pc_rd,
  input  logic [SW-1:0]       stk_wr,
  input  logic [SW-1:0]       stk_rd,
  output bfm_pkg::op_t        op_q,
  output logic [PW-1:0]       open_q,
  output logic [PW-1:0]       close_q
);
  import bfm_pkg::*;

  op_t         prog_mem  [PROG_DEPTH];
  logic [PW-1:0] open_tab  [PROG_DEPTH];
  logic [PW-1:0] close_tab [PROG_DEPTH];
  logic [PW-1:0] stk_mem   [NEST_DEPTH];

  op_t         op_r;
  logic [PW-1:0] open_r;
  logic [PW-1:0] close_r;
  logic [PW-1:0] top_r;

  always_ff @(posedge clk) begin
    if (ctl.prog_we) begin
      prog_mem[wr_pos] <= wr_op;
    end
    op_r <= (ctl.prog_we && wr_pos == pc_rd) ? wr_op : prog_mem[pc_rd];
  end

  // close entry points back at its open, open entry points forward at its close
  always_ff @(posedge clk) begin
    if (ctl.tab_we) begin
      close_tab[wr_pos] <= top_r;
      open_tab[top_r]   <= wr_pos;
    end
    close_r <= (ctl.tab_we && wr_pos == pc_rd) ? top_r : close_tab[pc_rd];
    open_r  <= (ctl.tab_we && top_r == pc_rd) ? wr_pos : open_tab[pc_rd];
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stk_mem[stk_wr] <= wr_pos;
    end
    top_r <= (ctl.push && stk_wr == stk_rd) ? wr_pos : stk_mem[stk_rd];
  end

  assign op_q    = op_r;
  assign open_q  = open_r;
  assign close_q = close_r;

endmodule

@@ design/bfm_tape.sv @@
// tape ring memory with clear sweep and prefetched cell read
module bfm_tape #(
  parameter int TAPE_CELLS = bfm_pkg::TAPE_CELLS_DEF,
  parameter int TW = $clog2(TAPE_CELLS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr_start,
  input  logic          we,
  input  logic [TW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [TW-1:0] raddr,
  output logic [7:0]    rdata,
  output logic          clr_busy
);
  import bfm_pkg::*;

  logic [7:0]    tape_mem [TAPE_CELLS];
  logic          clr_busy_r;
  logic [TW-1:0] clr_addr_r;
  logic [7:0]    rdata_r;
  logic          wr_en;
  logic [TW-1:0] wr_addr;
  logic [7:0]    wr_dat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_start) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == TW'(TAPE_CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + TW'(1);
    end
  end

  always_comb begin
    wr_en   = clr_busy_r || we;
    wr_addr = clr_busy_r ? clr_addr_r : waddr;
    wr_dat  = clr_busy_r ? 8'd0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tape_mem[wr_addr] <= wr_dat;
    end
    rdata_r <= (wr_en && wr_addr == raddr) ? wr_dat : tape_mem[raddr];
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ design/brainfuck_machine_unit.sv @@
// brainfuck machine top level: input register, execute logic, result register
// a transaction stalls in the input register during a sweep or out stall, then is registered
// throughput: one transaction per cycle outside stalls, via prefetched program and tape reads
// a start transaction clears all TAPE_CELLS tape cells in a sweep, in_tready low meanwhile
// reset clears control state and also runs the tape clear sweep before in_tready rises
module brainfuck_machine_unit #(
  parameter int PROG_DEPTH = bfm_pkg::PROG_DEPTH_DEF,
  parameter int TAPE_CELLS = bfm_pkg::TAPE_CELLS_DEF,
  parameter int NEST_DEPTH = bfm_pkg::NEST_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bfm_pkg::IN_TDATA_W-1:0]   in_tdata,  // symbol, in_byte
  input  logic [bfm_pkg::IN_TUSER_W-1:0]   in_tuser,  // req_type[1:0], in_valid
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bfm_pkg::OUT_TDATA_W-1:0]  out_tdata, // out_byte, status, zero pad
  output logic                             out_tuser  // out_valid
);
  import bfm_pkg::*;

  localparam int PW  = $clog2(PROG_DEPTH);
  localparam int PLW = $clog2(PROG_DEPTH + 1);
  localparam int SW  = $clog2(NEST_DEPTH);
  localparam int DW  = $clog2(NEST_DEPTH + 1);
  localparam int TW  = $clog2(TAPE_CELLS);

  // input register
  logic       in_vld_r;
  req_t       in_req_r;
  logic [7:0] in_sym_r;
  logic [7:0] in_byte_r;
  logic       in_iv_r;

  // machine state
  logic [DW-1:0]  stk_depth_r, stk_depth_nxt;
  logic [PLW-1:0] prog_len_r, prog_len_nxt;
  logic [PLW-1:0] pc_r, pc_nxt;
  logic [TW-1:0]  head_r, head_nxt;
  status_t        err_r, err_nxt;

  // result register
  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic       out_flag_r;
  status_t    out_st_r;

  logic       exec_fire;
  logic       clr_busy;
  logic       clr_start;
  prog_ctl_t  ctl_c, prog_ctl;
  dec_t       dec;
  op_t        op_q;
  logic [PW-1:0] open_q, close_q;
  logic [7:0] tape_q;
  logic       tape_we_c;
  logic [7:0] tape_wdata;
  logic [7:0] res_byte;
  logic       res_flag;
  status_t    res_st;

  assign exec_fire = in_vld_r && !clr_busy && (!out_vld_r || out_tready);
  assign in_tready = !clr_busy && (!in_vld_r || exec_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r  <= req_t'(in_tuser[1:0]);
      in_iv_r   <= in_tuser[2];
      in_sym_r  <= in_tdata[7:0];
      in_byte_r <= in_tdata[15:8];
    end
  end

  always_comb begin
    stk_depth_nxt = stk_depth_r;
    prog_len_nxt  = prog_len_r;
    pc_nxt        = pc_r;
    head_nxt      = head_r;
    err_nxt       = err_r;
    ctl_c         = '0;
    tape_we_c     = 1'b0;
    tape_wdata    = tape_q;
    clr_start     = 1'b0;
    res_byte      = 8'd0;
    res_flag      = 1'b0;
    res_st        = err_r;
    dec           = decode_symbol(in_sym_r);
    unique case (in_req_r)
      REQ_LOAD: begin
        if (dec.vld && err_r == ST_OK) begin
          if (prog_len_r >= PLW'(PROG_DEPTH)) begin
            err_nxt = ST_OVER;
          end else if (dec.op == OP_OPEN && stk_depth_r >= DW'(NEST_DEPTH)) begin
            err_nxt = ST_OVER;
          end else if (dec.op == OP_CLOSE && stk_depth_r == '0) begin
            err_nxt = ST_CLOSE;
          end else begin
            ctl_c.prog_we = 1'b1;
            prog_len_nxt  = prog_len_r + PLW'(1);
            if (dec.op == OP_OPEN) begin
              ctl_c.push    = 1'b1;
              stk_depth_nxt = stk_depth_r + DW'(1);
            end else if (dec.op == OP_CLOSE) begin
              ctl_c.tab_we  = 1'b1;
              stk_depth_nxt = stk_depth_r - DW'(1);
            end
          end
        end
        res_st = err_nxt;
      end
      REQ_START: begin
        clr_start = 1'b1;
        head_nxt  = '0;
        pc_nxt    = '0;
        if (err_r == ST_OK && stk_depth_r != '0) begin
          err_nxt = ST_OPEN;
        end
        res_st = err_nxt;
      end
      REQ_TICK: begin
        if (err_r != ST_OK) begin
          res_st = err_r;
        end else if (stk_depth_r != '0) begin
          err_nxt = ST_OPEN;
          res_st  = ST_OPEN;
        end else if (pc_r >= prog_len_r) begin
          res_st = ST_HALT;
        end else begin
          res_st = ST_OK;
          pc_nxt = pc_r + PLW'(1);
          case (op_q)
            OP_INC: begin
              tape_we_c  = 1'b1;
              tape_wdata = tape_q + 8'd1;
            end
            OP_DEC: begin
              tape_we_c  = 1'b1;
              tape_wdata = tape_q - 8'd1;
            end
            OP_LEFT:  head_nxt = head_r - TW'(1);
            OP_RIGHT: head_nxt = head_r + TW'(1);
            OP_OPEN: begin
              if (tape_q == 8'd0) begin
                pc_nxt = PLW'(open_q);
              end
            end
            OP_CLOSE: begin
              if (tape_q != 8'd0) begin
                pc_nxt = PLW'(close_q);
              end
            end
            OP_OUT: begin
              res_byte = tape_q;
              res_flag = 1'b1;
            end
            OP_IN: begin
              if (in_iv_r) begin
                tape_we_c  = 1'b1;
                tape_wdata = in_byte_r;
              end else begin
                res_st = ST_WAIT;
                pc_nxt = pc_r;
              end
            end
            default: ;
          endcase
        end
      end
      default: res_st = err_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_depth_r <= '0;
      prog_len_r  <= '0;
      pc_r        <= '0;
      head_r      <= '0;
      err_r       <= ST_OK;
      out_vld_r   <= 1'b0;
    end else begin
      if (exec_fire) begin
        stk_depth_r <= stk_depth_nxt;
        prog_len_r  <= prog_len_nxt;
        pc_r        <= pc_nxt;
        head_r      <= head_nxt;
        err_r       <= err_nxt;
        out_vld_r   <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_byte_r <= res_byte;
      out_flag_r <= res_flag;
      out_st_r   <= res_st;
    end
  end

  assign prog_ctl = exec_fire ? ctl_c : '0;

  // reads are prefetched at the next-state addresses
  logic [PLW-1:0] pc_rd_full;
  logic [TW-1:0]  head_rd;
  logic [DW-1:0]  stk_rd_full;

  always_comb begin
    pc_rd_full  = exec_fire ? pc_nxt : pc_r;
    head_rd     = exec_fire ? head_nxt : head_r;
    stk_rd_full = (exec_fire ? stk_depth_nxt : stk_depth_r) - DW'(1);
  end

  bfm_prog #(
    .PROG_DEPTH (PROG_DEPTH),
    .NEST_DEPTH (NEST_DEPTH),
    .PW         (PW),
    .SW         (SW)
  ) u_prog (
    .clk     (clk),
    .ctl     (prog_ctl),
    .wr_pos  (prog_len_r[PW-1:0]),
    .wr_op   (dec.op),
    .pc_rd   (pc_rd_full[PW-1:0]),
    .stk_wr  (stk_depth_r[SW-1:0]),
    .stk_rd  (stk_rd_full[SW-1:0]),
    .op_q    (op_q),
    .open_q  (open_q),
    .close_q (close_q)
  );

  bfm_tape #(
    .TAPE_CELLS (TAPE_CELLS),
    .TW         (TW)
  ) u_tape (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (exec_fire && clr_start),
    .we        (exec_fire && tape_we_c),
    .waddr     (head_r),
    .wdata     (tape_wdata),
    .raddr     (head_rd),
    .rdata     (tape_q),
    .clr_busy  (clr_busy)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_st_r, out_byte_r};
  assign out_tuser  = out_flag_r;

  a_no_accept_in_sweep : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("transaction accepted during tape clear sweep");

  a_depth_bound : assert property (@(posedge clk) disable iff (!rst_n)
    stk_depth_r <= DW'(NEST_DEPTH))
    else $error("bracket stack depth beyond limit");

  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    prog_len_r <= PLW'(PROG_DEPTH))
    else $error("program length beyond limit");

  a_err_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |=> (err_r == $past(err_r)))
    else $error("error code changed after being set");

  a_print_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_flag_r) |-> (out_st_r == ST_OK))
    else $error("printed byte with non-ok status");

endmodule
